// ===== sv/smac_pkg.sv =====
// Shared types and constants for the moving average crossover detector.
// No dependencies; every other file imports this package.
package smac_pkg;

    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_WIDTH = 32;

    // Derived sizes
    localparam int PTR_W   = $clog2(MAX_WINDOW);
    localparam int COUNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_WIDTH + PTR_W;
    localparam int STEP_W  = $clog2(SUM_W + 1);

    // Window registers are 9 bits wide
    localparam int WIN_W = 9;

    typedef enum logic [0:0] {
        CFG_FAST_WINDOW = 1'b0,
        CFG_SLOW_WINDOW = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           restart;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] fast_average;
        logic signed [SAMPLE_WIDTH-1:0] slow_average;
        logic                           fast_full;
        logic                           slow_full;
        logic                           buy;
        logic                           sell;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_F,
        ST_RD_S,
        ST_WR,
        ST_ADD_F,
        ST_ADD_S,
        ST_RB_F,
        ST_RB_S,
        ST_DIV_F,
        ST_WAIT_F,
        ST_DIV_S,
        ST_WAIT_S,
        ST_CMP
    } smac_state_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic [SAMPLE_WIDTH-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/smac_divider.sv =====
// Radix-2 restoring divider: signed windowed sum by unsigned window size.
// One quotient bit per cycle, quotient truncated toward zero. Uses smac_pkg.
module smac_divider
    import smac_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              neg_reg, neg_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [WIN_W-1:0]  rem_reg, rem_next;
    logic [WIN_W-1:0]  div_reg, div_next;

    logic [WIN_W:0]    trial;
    logic              fits;
    logic [WIN_W:0]    diff;
    logic [SUM_W-1:0]  quo_signed;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(SUM_W);
            neg_next  = req.dividend[SUM_W-1];
            quo_next  = req.dividend[SUM_W-1] ? (~req.dividend + SUM_W'(1)) : req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    // Restore the sign of the quotient
    assign quo_signed   = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_signed[SAMPLE_WIDTH-1:0];

endmodule

// ===== sv/moving_average_crossover_detector_unit.sv =====
// Dual simple moving average crossover detector: one item in, one result item out.
// From one accepted item to the next: five sequencer steps on the shared 40-bit adder,
// then per full window a start step and a wait on the radix-2 divider (only the start
// step for a window that is not full), then the compare, then an idle step with the
// input ready. The result item becomes valid in the same cycle as the input is ready
// again; a stalled result holds the sequencer in the compare step. Sums are updated
// incrementally; after a window size is changed mid-series the next item first
// rebuilds that sum from the history memory, reading min(samples held, window)
// samples per changed window.
// No clearing pass is needed after reset. Uses smac_pkg and smac_divider.
module moving_average_crossover_detector_unit
    import smac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_item,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [WIN_W-1:0] cfg_data
);

    smac_state_t state_reg, state_next;

    logic [WIN_W-1:0]   fast_window_reg, slow_window_reg;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_f_reg, sum_f_next;
    logic [SUM_W-1:0]   sum_s_reg, sum_s_next;
    logic [WIN_W-1:0]   win_f_reg, win_f_next;
    logic [WIN_W-1:0]   win_s_reg, win_s_next;
    logic               prev_pos_reg, prev_pos_next;
    logic               prev_neg_reg, prev_neg_next;
    logic               armed_reg, armed_next;
    logic [COUNT_W-1:0] issue_reg, issue_next;
    logic               rdv_reg, rdv_next;
    logic               out_valid_reg, out_valid_next;

    logic [SAMPLE_WIDTH-1:0] x_reg, x_next;
    logic [SAMPLE_WIDTH-1:0] favg_reg, favg_next;
    logic [SAMPLE_WIDTH-1:0] savg_reg, savg_next;
    out_item_t               out_item_reg, out_item_next;

    logic [SAMPLE_WIDTH-1:0] hist_mem [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] mem_rd_data_reg;
    logic [PTR_W-1:0]        mem_raddr;
    logic                    mem_we;

    logic [WIN_W-1:0]   fw_cl, sw_cl;
    logic [COUNT_W-1:0] len_f, len_s, rb_len;
    logic               rb_issue, rb_done;
    logic [PTR_W-1:0]   rb_addr;
    logic               fast_full, slow_full;
    logic               drop_f, drop_s;
    logic               f_mis, s_mis;
    logic               in_fire, out_free;
    logic [SUM_W-1:0]   rd_ext, x_ext, favg_ext, savg_ext;
    logic [SUM_W-1:0]   add_a, add_b, add_res;
    logic               add_sub;
    logic               diff_pos, diff_neg;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Handshakes
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Clamp windows to the history depth
    assign fw_cl = (32'(fast_window_reg) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : fast_window_reg;
    assign sw_cl = (32'(slow_window_reg) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : slow_window_reg;

    // Window status against the sample count
    assign fast_full = (fw_cl != '0) && (32'(cnt_reg) >= 32'(fw_cl));
    assign slow_full = (sw_cl != '0) && (32'(cnt_reg) >= 32'(sw_cl));
    assign drop_f    = fast_full;
    assign drop_s    = slow_full;
    assign f_mis     = (win_f_reg != fw_cl);
    assign s_mis     = (win_s_reg != sw_cl);

    // Rebuild walk, newest sample first
    assign len_f    = (32'(cnt_reg) < 32'(fw_cl)) ? cnt_reg : COUNT_W'(fw_cl);
    assign len_s    = (32'(cnt_reg) < 32'(sw_cl)) ? cnt_reg : COUNT_W'(sw_cl);
    assign rb_len   = (state_reg == ST_RB_F) ? len_f : len_s;
    assign rb_issue = (issue_reg < rb_len);
    assign rb_done  = !rb_issue && !rdv_reg;
    assign rb_addr  = ptr_reg - PTR_W'(1) - PTR_W'(issue_reg);

    // Sign-extended operands
    assign rd_ext   = {{PTR_W{mem_rd_data_reg[SAMPLE_WIDTH-1]}}, mem_rd_data_reg};
    assign x_ext    = {{PTR_W{x_reg[SAMPLE_WIDTH-1]}}, x_reg};
    assign favg_ext = {{PTR_W{favg_reg[SAMPLE_WIDTH-1]}}, favg_reg};
    assign savg_ext = {{PTR_W{savg_reg[SAMPLE_WIDTH-1]}}, savg_reg};

    // Shared adder
    assign add_res  = add_sub ? (add_a - add_b) : (add_a + add_b);
    assign diff_neg = add_res[SUM_W-1];
    assign diff_pos = !add_res[SUM_W-1] && (|add_res);

    // History memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[ptr_reg] <= x_reg;
        end
        mem_rd_data_reg <= hist_mem[mem_raddr];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RD_F;
                end
            end
            ST_RD_F:  state_next = ST_RD_S;
            ST_RD_S:  state_next = ST_WR;
            ST_WR:    state_next = ST_ADD_F;
            ST_ADD_F: state_next = ST_ADD_S;
            ST_ADD_S:
            begin
                if (f_mis)
                begin
                    state_next = ST_RB_F;
                end
                else if (s_mis)
                begin
                    state_next = ST_RB_S;
                end
                else
                begin
                    state_next = ST_DIV_F;
                end
            end
            ST_RB_F:
            begin
                if (rb_done)
                begin
                    state_next = s_mis ? ST_RB_S : ST_DIV_F;
                end
            end
            ST_RB_S:
            begin
                if (rb_done)
                begin
                    state_next = ST_DIV_F;
                end
            end
            ST_DIV_F:  state_next = fast_full ? ST_WAIT_F : ST_DIV_S;
            ST_WAIT_F:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DIV_S;
                end
            end
            ST_DIV_S:  state_next = slow_full ? ST_WAIT_S : ST_CMP;
            ST_WAIT_S:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory address and write enable, adder operands, divider request
    always_comb
    begin
        mem_raddr        = ptr_reg;
        mem_we           = 1'b0;
        add_a            = sum_f_reg;
        add_b            = rd_ext;
        add_sub          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_f_reg;
        div_req.divisor  = fw_cl;
        case (state_reg)
            ST_RD_F:
            begin
                mem_raddr = ptr_reg - PTR_W'(fw_cl);
            end
            ST_RD_S:
            begin
                mem_raddr = ptr_reg - PTR_W'(sw_cl);
                add_sub   = 1'b1;
            end
            ST_WR:
            begin
                mem_we  = 1'b1;
                add_a   = sum_s_reg;
                add_sub = 1'b1;
            end
            ST_ADD_F:
            begin
                add_b = x_ext;
            end
            ST_ADD_S:
            begin
                add_a = sum_s_reg;
                add_b = x_ext;
            end
            ST_RB_F:
            begin
                mem_raddr = rb_addr;
            end
            ST_RB_S:
            begin
                mem_raddr = rb_addr;
                add_a     = sum_s_reg;
            end
            ST_DIV_F:
            begin
                div_req.start = fast_full;
            end
            ST_DIV_S:
            begin
                div_req.start    = slow_full;
                div_req.dividend = sum_s_reg;
                div_req.divisor  = sw_cl;
            end
            ST_CMP:
            begin
                add_a   = favg_ext;
                add_b   = savg_ext;
                add_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        sum_f_next     = sum_f_reg;
        sum_s_next     = sum_s_reg;
        win_f_next     = win_f_reg;
        win_s_next     = win_s_reg;
        prev_pos_next  = prev_pos_reg;
        prev_neg_next  = prev_neg_reg;
        armed_next     = armed_reg;
        issue_next     = issue_reg;
        rdv_next       = rdv_reg;
        x_next         = x_reg;
        favg_next      = favg_reg;
        savg_next      = savg_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next = in_item.sample;
                    // A new series starts with empty history and zero sums
                    if (in_item.restart)
                    begin
                        ptr_next      = '0;
                        cnt_next      = '0;
                        sum_f_next    = '0;
                        sum_s_next    = '0;
                        win_f_next    = fw_cl;
                        win_s_next    = sw_cl;
                        prev_pos_next = 1'b0;
                        prev_neg_next = 1'b0;
                        armed_next    = 1'b0;
                    end
                end
            end
            ST_RD_S:
            begin
                // Drop the oldest fast sample
                if (drop_f)
                begin
                    sum_f_next = add_res;
                end
            end
            ST_WR:
            begin
                // Drop the oldest slow sample, advance pointer and count
                if (drop_s)
                begin
                    sum_s_next = add_res;
                end
                ptr_next = ptr_reg + PTR_W'(1);
                if (32'(cnt_reg) < MAX_WINDOW)
                begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_ADD_F:
            begin
                if (fw_cl != '0)
                begin
                    sum_f_next = add_res;
                end
            end
            ST_ADD_S:
            begin
                if (sw_cl != '0)
                begin
                    sum_s_next = add_res;
                end
                // Clear a sum whose window changed before rebuilding it
                if (state_next == ST_RB_F)
                begin
                    sum_f_next = '0;
                    issue_next = '0;
                    rdv_next   = 1'b0;
                end
                else if (state_next == ST_RB_S)
                begin
                    sum_s_next = '0;
                    issue_next = '0;
                    rdv_next   = 1'b0;
                end
            end
            ST_RB_F:
            begin
                if (rdv_reg)
                begin
                    sum_f_next = add_res;
                end
                issue_next = issue_reg + COUNT_W'(rb_issue);
                rdv_next   = rb_issue;
                if (rb_done)
                begin
                    win_f_next = fw_cl;
                end
                if (state_next == ST_RB_S)
                begin
                    sum_s_next = '0;
                    issue_next = '0;
                    rdv_next   = 1'b0;
                end
            end
            ST_RB_S:
            begin
                if (rdv_reg)
                begin
                    sum_s_next = add_res;
                end
                issue_next = issue_reg + COUNT_W'(rb_issue);
                rdv_next   = rb_issue;
                if (rb_done)
                begin
                    win_s_next = sw_cl;
                end
            end
            ST_DIV_F:
            begin
                if (!fast_full)
                begin
                    favg_next = '0;
                end
            end
            ST_WAIT_F:
            begin
                if (div_rsp.done)
                begin
                    favg_next = div_rsp.quotient;
                end
            end
            ST_DIV_S:
            begin
                if (!slow_full)
                begin
                    savg_next = '0;
                end
            end
            ST_WAIT_S:
            begin
                if (div_rsp.done)
                begin
                    savg_next = div_rsp.quotient;
                end
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    out_item_next.fast_average = favg_reg;
                    out_item_next.slow_average = savg_reg;
                    out_item_next.fast_full    = fast_full;
                    out_item_next.slow_full    = slow_full;
                    out_item_next.buy          = 1'b0;
                    out_item_next.sell         = 1'b0;
                    // Compare the sign of the difference with the last one
                    if ((fw_cl != '0) && slow_full)
                    begin
                        out_item_next.buy  = armed_reg && diff_pos && !prev_pos_reg;
                        out_item_next.sell = armed_reg && diff_neg && !prev_neg_reg;
                        prev_pos_next      = diff_pos;
                        prev_neg_next      = diff_neg;
                        armed_next         = 1'b1;
                    end
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            fast_window_reg <= WIN_W'(1);
            slow_window_reg <= WIN_W'(1);
            ptr_reg         <= '0;
            cnt_reg         <= '0;
            sum_f_reg       <= '0;
            sum_s_reg       <= '0;
            win_f_reg       <= WIN_W'(1);
            win_s_reg       <= WIN_W'(1);
            prev_pos_reg    <= 1'b0;
            prev_neg_reg    <= 1'b0;
            armed_reg       <= 1'b0;
            issue_reg       <= '0;
            rdv_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            sum_f_reg     <= sum_f_next;
            sum_s_reg     <= sum_s_next;
            win_f_reg     <= win_f_next;
            win_s_reg     <= win_s_next;
            prev_pos_reg  <= prev_pos_next;
            prev_neg_reg  <= prev_neg_next;
            armed_reg     <= armed_next;
            issue_reg     <= issue_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FAST_WINDOW: fast_window_reg <= cfg_data;
                    CFG_SLOW_WINDOW: slow_window_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        favg_reg     <= favg_next;
        savg_reg     <= savg_next;
        out_item_reg <= out_item_next;
    end

    smac_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

// ===== sv/smac_checker.sv =====
// Port-level checks for the moving average crossover detector, bound to the top level.
// Uses smac_pkg.
module smac_checker
    import smac_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input in_item_t         in_item,
    input logic             out_valid,
    input logic             out_ready,
    input out_item_t        out_item,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input cfg_index_t       cfg_index,
    input logic [WIN_W-1:0] cfg_data
);

    // Hold off the next item while one is at work
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after an accepted item");

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result item changed or dropped");

    // Never flag both directions
    a_buy_sell_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_item.buy && out_item.sell))
        else $error("buy and sell flagged together");

    // A crossing needs a full slow window
    a_cross_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.buy || out_item.sell) |-> out_item.slow_full)
        else $error("crossing flagged before slow window filled");

    // Averages read zero until their windows fill
    a_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.fast_full || (out_item.fast_average == '0)) &&
                      (out_item.slow_full || (out_item.slow_average == '0)))
        else $error("average nonzero before its window filled");

endmodule

bind moving_average_crossover_detector_unit smac_checker u_smac_checker (.*);

// ===== tb/sv/crossover_checker.sv =====
`timescale 1ns / 100ps
// Checker for the moving average crossover detector: watches the config, input
// and result channels, predicts each result item and compares it field by field.
// Depends on smac_pkg for the item types, the register index and the sizes.
module crossover_checker
    import smac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_item_t         in_item,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_item_t        out_item,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  cfg_index_t       cfg_index,
    input  logic [WIN_W-1:0] cfg_data,
    output int               pending,
    output int               failures
);

    // Predictor copy of the block's registers and series state
    logic [WIN_W-1:0] fast_win;
    logic [WIN_W-1:0] slow_win;
    longint           sample_hist [MAX_WINDOW];
    int unsigned      wr_ptr;
    int unsigned      held;
    int               prev_sign;
    bit               armed;

    out_item_t        predicted_items [$];

    // Average of the newest w samples, zero until w samples are held
    function automatic longint window_average(int unsigned w);
        longint      total;
        int unsigned idx;
        total = 0;
        idx = wr_ptr;
        if (w == 0 || held < w)
            return 0;
        for (int unsigned k = 0; k < w; k++)
        begin
            idx = (idx == 0) ? MAX_WINDOW - 1 : idx - 1;
            total += sample_hist[idx];
        end
        return total / longint'(w);
    endfunction

    // Take one sample into the series and work out its result item
    function automatic out_item_t predict_averages(in_item_t item);
        out_item_t   res;
        int unsigned fw;
        int unsigned sw;
        longint      fast_avg;
        longint      slow_avg;
        longint      diff;
        int          sign;
        fw = (fast_win > MAX_WINDOW) ? MAX_WINDOW : fast_win;
        sw = (slow_win > MAX_WINDOW) ? MAX_WINDOW : slow_win;
        if (item.restart)
        begin
            wr_ptr = 0;
            held = 0;
            prev_sign = 0;
            armed = 1'b0;
        end
        sample_hist[wr_ptr] = longint'($signed(item.sample));
        wr_ptr = (wr_ptr + 1) % MAX_WINDOW;
        if (held < MAX_WINDOW)
            held++;
        fast_avg = window_average(fw);
        slow_avg = window_average(sw);
        res = '0;
        res.fast_average = fast_avg[SAMPLE_WIDTH-1:0];
        res.slow_average = slow_avg[SAMPLE_WIDTH-1:0];
        res.fast_full = (fw != 0) && (held >= fw);
        res.slow_full = (sw != 0) && (held >= sw);
        // Crossing test runs only with both windows enabled and the slow one full;
        // an unfilled fast average counts as zero here
        if (fw != 0 && res.slow_full)
        begin
            diff = fast_avg - slow_avg;
            sign = (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
            if (armed)
            begin
                if (sign > 0 && prev_sign <= 0)
                    res.buy = 1'b1;
                else if (sign < 0 && prev_sign >= 0)
                    res.sell = 1'b1;
            end
            prev_sign = sign;
            armed = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (got !== want)
        begin
            failures++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fast_win = WIN_W'(1);
            slow_win = WIN_W'(1);
            wr_ptr = 0;
            held = 0;
            prev_sign = 0;
            armed = 1'b0;
            predicted_items.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FAST_WINDOW: fast_win = cfg_data;
                    CFG_SLOW_WINDOW: slow_win = cfg_data;
                    default: ;
                endcase
            end
            // Compare a result item against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (predicted_items.size() == 0)
                begin
                    failures++;
                    $error("result item with no sample waiting for it");
                end
                else
                begin
                    want = predicted_items.pop_front();
                    check_field("fast_average", want.fast_average, out_item.fast_average);
                    check_field("slow_average", want.slow_average, out_item.slow_average);
                    check_field("fast_full", want.fast_full, out_item.fast_full);
                    check_field("slow_full", want.slow_full, out_item.slow_full);
                    check_field("buy", want.buy, out_item.buy);
                    check_field("sell", want.sell, out_item.sell);
                end
            end
            // Predict each accepted sample and queue it behind the others
            if (in_valid && in_ready)
                predicted_items.insert(predicted_items.size(), predict_averages(in_item));
            pending <= predicted_items.size();
        end
    end

endmodule

// ===== tb/sv/moving_average_crossover_detector_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the crossover detector testbench: clock, reset, register writes, sample
// stimulus, result back-pressure, watchdog and verdict. Uses smac_pkg and crossover_checker.
module moving_average_crossover_detector_unit_tb
    import smac_pkg::*;
();

    localparam int SERIES_ITEMS = 1800;
    localparam int LONG_HOLD    = 600;
    // Slowest item is a full rebuild of both sums plus two divisions
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 200;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_item = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    cfg_index_t       cfg_index = CFG_FAST_WINDOW;
    logic [WIN_W-1:0] cfg_data = '0;

    int               pending;
    int               failures;
    int               stalled_cycles = 0;
    bit               quiet = 1'b0;
    longint           price = 0;
    longint           swing = 16;
    int               trend = 1;

    moving_average_crossover_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    crossover_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offer one sample after a random gap and hold it until accepted
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic fresh);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.sample <= value;
        in_item.restart <= fresh;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic write_window(input cfg_index_t idx, input logic [WIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
    endtask

    // Drain every outstanding result, then load both windows
    task automatic set_windows(input logic [WIN_W-1:0] fast_w, input logic [WIN_W-1:0] slow_w);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        write_window(CFG_FAST_WINDOW, fast_w);
        write_window(CFG_SLOW_WINDOW, slow_w);
        cfg_valid <= 1'b0;
    endtask

    // Next series value: mostly a drifting random walk, some full-range noise and extremes
    function automatic logic [SAMPLE_WIDTH-1:0] next_price();
        case ($urandom_range(0, 19))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 14) == 0)
                    trend = -trend;
                price += longint'($urandom_range(0, 32'(2 * swing))) - swing
                         + trend * (swing / 4);
                if (price > 64'sd2147483647)
                    price = 64'sd2147483647;
                else if (price < -64'sd2147483648)
                    price = -64'sd2147483648;
                return price[SAMPLE_WIDTH-1:0];
            end
        endcase
    endfunction

    // Result side: random stalls, plus two long holds to back the block up
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            if (taken == 500 || taken == 1300)
                stall = LONG_HOLD;
            else
                stall = quiet ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            taken++;
        end
    end

    // Abort when no channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("[moving_average_crossover_detector_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int fast_w;
        int slow_w;
        int span;
        int length;
        bit fresh;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, sell then buy on a full-scale swing
        set_windows(WIN_W'(2), WIN_W'(4));
        send_sample(32'h7FFF_FFFF, 1'b1);
        repeat (3) send_sample(32'h7FFF_FFFF, 1'b0);
        repeat (3) send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        repeat (2) send_sample(32'h7FFF_FFFF, 1'b0);

        // Directed: disabled fast window, slow window above the maximum
        set_windows(WIN_W'(0), WIN_W'(300));
        send_sample(32'd5, 1'b1);
        send_sample(-32'sd5, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);

        // Directed: slow full before fast, so fast counts as zero in the difference
        set_windows(WIN_W'(3), WIN_W'(1));
        send_sample(32'd100, 1'b1);
        send_sample(32'd200, 1'b0);
        send_sample(-32'sd300, 1'b0);
        send_sample(32'd50, 1'b0);

        // Directed: windows changed mid-series, crossing state kept
        set_windows(WIN_W'(1), WIN_W'(2));
        send_sample(32'd1000, 1'b0);
        send_sample(-32'sd1000, 1'b0);
        send_sample(32'd7, 1'b0);

        // Random phases; the first one fills the largest window
        for (int phase = 0; sent < SERIES_ITEMS; phase++)
        begin
            if (phase == 0)
            begin
                fast_w = 511;
                slow_w = 256;
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0:
                    begin
                        fast_w = 0;
                        slow_w = $urandom_range(1, 16);
                    end
                    1:
                    begin
                        fast_w = $urandom_range(1, 16);
                        slow_w = 0;
                    end
                    2:
                    begin
                        fast_w = $urandom_range(1, 511);
                        slow_w = $urandom_range(1, 511);
                    end
                    default:
                    begin
                        slow_w = $urandom_range(2, 32);
                        fast_w = $urandom_range(1, slow_w);
                        if ($urandom_range(0, 5) == 0)
                            fast_w = $urandom_range(slow_w, 40);
                    end
                endcase
            end
            fresh = (phase == 0) || ($urandom_range(0, 3) != 0);
            span = (fast_w > slow_w) ? fast_w : slow_w;
            if (span > MAX_WINDOW)
                span = MAX_WINDOW;
            length = fresh ? span + $urandom_range(20, 100) : $urandom_range(20, 100);
            swing = 64'sd1 << (2 + 6 * $urandom_range(0, 3));
            if (fresh)
                price = longint'($signed(32'($urandom))) / 4;
            quiet = ($urandom_range(0, 3) == 0);
            set_windows(WIN_W'(fast_w), WIN_W'(slow_w));
            for (int k = 0; k < length; k++)
            begin
                send_sample(next_price(), (k == 0 && fresh) || ($urandom_range(0, 59) == 0));
                sent++;
            end
        end

        // Let the block finish and verify nothing extra shows up
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("[moving_average_crossover_detector_unit] OK");
        else
            $display("[moving_average_crossover_detector_unit] ERROR");
        $finish;
    end

endmodule
